// ----- rtl/cpseg_pkg.sv -----
// Shared constants for the segment closest-point pipeline.
`timescale 1ns / 1ps
package cpseg_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int RATIO_BITS      = 32;  // fraction bits of s and t
  localparam int MUL_CHUNK       = 16;  // multiplier operand slice per stage
  localparam int LIMIT_WIDTH     = 32;
  localparam int GAP_WIDTH       = 64;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1);
endpackage

// ----- rtl/closest_points_between_segments_core.sv -----
// Top level: closest points between two 3D segments, fully pipelined.
`timescale 1ns / 1ps
// Takes one segment pair per clock, unless the output stalls, and returns the
// nearest point on each segment plus their squared distance (2x the coordinate
// fraction bits, saturating at 2^64-1). Most of the depth lies in the two
// bit-per-stage ratio pipelines (s, then t). The whole pipe advances together;
// it holds when a result is presented and not taken.
module closest_points_between_segments_core import cpseg_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [LIMIT_WIDTH-1:0]            cfg_wdata,   // degenerate_limit
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_a_x,y,z, end_a_x,y,z, start_b_x,y,z, end_b_x,y,z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // near_a_x,y,z, near_b_x,y,z, gap_squared
  output logic [((6*COORD_WIDTH+GAP_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int CW   = COORD_WIDTH;
  localparam int RB   = RATIO_BITS;
  localparam int OW   = ((6*CW + GAP_WIDTH + 7) / 8) * 8;
  localparam int DLW  = CW + 1;
  localparam int PW1  = 2 * DLW;
  localparam int DW   = PW1 + 2;
  localparam int MW   = 2 * DW;
  localparam int NW   = DW + RB + 3;
  localparam int LM1  = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LM2  = (RB + 2 + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int LR   = RB + 1;
  localparam int J1   = LM1 + 1 + LR;
  localparam int K    = J1 + LM2 + 1;
  localparam int DL   = K + LR;
  localparam int APW  = DLW + RB + 2;
  localparam int SQW  = 2 * (CW + 2);
  localparam int GW   = SQW + 2;
  localparam int GXW  = (GW > GAP_WIDTH) ? GW : GAP_WIDTH + 1;
  localparam logic [RB:0] ONE = (RB+1)'(1) << RB;

  typedef struct packed {
    logic [2:0][CW-1:0]  pa;
    logic [2:0][CW-1:0]  pb;
    logic [2:0][DLW-1:0] d1;
    logic [2:0][DLW-1:0] d2;
    logic [DW-1:0]       a;
    logic [DW-1:0]       b;
    logic [DW-1:0]       c;
    logic [DW-1:0]       e;
    logic [DW-1:0]       f;
    logic                deg_a;
    logic                deg_b;
  } side_t;

  logic                   en;
  logic [LIMIT_WIDTH-1:0] limit;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // stage 1: edge vectors
  logic signed [CW-1:0]  crd [12];
  logic                  v1, v2;
  logic signed [CW-1:0]  pa1 [3], pb1 [3], pa2 [3], pb2 [3];
  logic signed [DLW-1:0] d1_1 [3], d2_1 [3], r1 [3], d1_2 [3], d2_2 [3];
  logic signed [PW1-1:0] pr2 [5][3];

  for (genvar j = 0; j < 12; j++) begin : g_crd
    assign crd[j] = s_axis_tdata[j*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa1[i]  <= crd[i];
        pb1[i]  <= crd[6+i];
        d1_1[i] <= DLW'(crd[3+i]) - DLW'(crd[i]);
        d2_1[i] <= DLW'(crd[9+i]) - DLW'(crd[6+i]);
        r1[i]   <= DLW'(crd[i]) - DLW'(crd[6+i]);
        // stage 2: dot product terms
        pr2[0][i] <= d1_1[i] * d1_1[i];
        pr2[1][i] <= d1_1[i] * d2_1[i];
        pr2[2][i] <= d1_1[i] * r1[i];
        pr2[3][i] <= d2_1[i] * d2_1[i];
        pr2[4][i] <= d2_1[i] * r1[i];
        pa2[i]  <= pa1[i];
        pb2[i]  <= pb1[i];
        d1_2[i] <= d1_1[i];
        d2_2[i] <= d2_1[i];
      end
    end
  end

  // stage 3: dot product sums and degenerate tests
  logic signed [DW-1:0] dsum [5];
  logic signed [DW-1:0] lim_x;

  assign lim_x = DW'({1'b0, limit});
  always_comb begin
    for (int m = 0; m < 5; m++) begin
      dsum[m] = DW'(pr2[m][0]) + DW'(pr2[m][1]) + DW'(pr2[m][2]);
    end
  end

  side_t sd [DL+1];
  logic  vl [DL+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DL; i++) begin
        vl[i] <= 1'b0;
      end
    end else if (en) begin
      vl[0] <= v2;
      for (int i = 1; i <= DL; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sd[0].pa[i] <= pa2[i];
        sd[0].pb[i] <= pb2[i];
        sd[0].d1[i] <= d1_2[i];
        sd[0].d2[i] <= d2_2[i];
      end
      sd[0].a     <= dsum[0];
      sd[0].b     <= dsum[1];
      sd[0].c     <= dsum[2];
      sd[0].e     <= dsum[3];
      sd[0].f     <= dsum[4];
      sd[0].deg_a <= dsum[0] <= lim_x;
      sd[0].deg_b <= dsum[3] <= lim_x;
      for (int i = 1; i <= DL; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // denominator a*e - b*b and numerator b*f - c*e
  logic signed [MW-1:0] ae, bb, bf, ce;
  logic signed [MW:0]   den_q, nn_q;

  cpseg_mul #(.WA(DW), .WB(DW)) u_mul_ae (
    .clk(clk), .en(en), .a($signed(sd[0].a)), .b($signed(sd[0].e)), .p(ae));
  cpseg_mul #(.WA(DW), .WB(DW)) u_mul_bb (
    .clk(clk), .en(en), .a($signed(sd[0].b)), .b($signed(sd[0].b)), .p(bb));
  cpseg_mul #(.WA(DW), .WB(DW)) u_mul_bf (
    .clk(clk), .en(en), .a($signed(sd[0].b)), .b($signed(sd[0].f)), .p(bf));
  cpseg_mul #(.WA(DW), .WB(DW)) u_mul_ce (
    .clk(clk), .en(en), .a($signed(sd[0].c)), .b($signed(sd[0].e)), .p(ce));

  always_ff @(posedge clk) begin
    if (en) begin
      den_q <= (MW+1)'(ae) - (MW+1)'(bb);
      nn_q  <= (MW+1)'(bf) - (MW+1)'(ce);
    end
  end

  // s of the general case, clamped to [0,1]; a zero denominator yields zero here
  logic [RB:0] s_gen;
  cpseg_ratio #(.W(MW+1)) u_ratio_s (
    .clk(clk), .en(en), .n(nn_q), .d(den_q), .q(s_gen));

  logic signed [DW+RB+1:0] bs;
  cpseg_mul #(.WA(DW), .WB(RB+2)) u_mul_bs (
    .clk(clk), .en(en), .a($signed(sd[J1].b)), .b($signed({1'b0, s_gen})), .p(bs));

  logic [RB:0] sgl [LM2+LR+1];
  always_ff @(posedge clk) begin
    if (en) begin
      sgl[0] <= s_gen;
      for (int i = 1; i <= LM2 + LR; i++) begin
        sgl[i] <= sgl[i-1];
      end
    end
  end

  // t numerator b*s + f and its bound, both at s scale
  logic signed [NW-1:0] num_q, lenb_q;
  always_ff @(posedge clk) begin
    if (en) begin
      num_q  <= NW'(bs) + (NW'($signed(sd[K-1].f)) <<< RB);
      lenb_q <= NW'($signed(sd[K-1].e)) <<< RB;
    end
  end

  logic fneg [LR], fbig [LR];
  always_ff @(posedge clk) begin
    if (en) begin
      fneg[0] <= num_q < 0;
      fbig[0] <= num_q > lenb_q;
      for (int i = 1; i < LR; i++) begin
        fneg[i] <= fneg[i-1];
        fbig[i] <= fbig[i-1];
      end
    end
  end

  logic [RB:0] t_gen, r_nc, r_bc, r_fe;
  cpseg_ratio #(.W(NW)) u_ratio_t (
    .clk(clk), .en(en), .n(num_q), .d(lenb_q), .q(t_gen));
  cpseg_ratio #(.W(DW+1)) u_ratio_nc (
    .clk(clk), .en(en), .n(-(DW+1)'($signed(sd[K].c))),
    .d((DW+1)'($signed(sd[K].a))), .q(r_nc));
  cpseg_ratio #(.W(DW+1)) u_ratio_bc (
    .clk(clk), .en(en), .n((DW+1)'($signed(sd[K].b)) - (DW+1)'($signed(sd[K].c))),
    .d((DW+1)'($signed(sd[K].a))), .q(r_bc));
  cpseg_ratio #(.W(DW+1)) u_ratio_fe (
    .clk(clk), .en(en), .n((DW+1)'($signed(sd[K].f))),
    .d((DW+1)'($signed(sd[K].e))), .q(r_fe));

  // case selection
  logic [RB:0] s_mux, t_mux, s_sel, t_sel;
  logic        vsel;
  always_comb begin
    s_mux = '0;
    t_mux = '0;
    if (sd[DL].deg_a && sd[DL].deg_b) begin
      s_mux = '0;
      t_mux = '0;
    end else if (sd[DL].deg_a) begin
      t_mux = r_fe;
    end else if (sd[DL].deg_b) begin
      s_mux = r_nc;
    end else if (fneg[LR-1]) begin
      s_mux = r_nc;
    end else if (fbig[LR-1]) begin
      s_mux = r_bc;
      t_mux = ONE;
    end else begin
      s_mux = sgl[LM2+LR];
      t_mux = t_gen;
    end
  end

  logic signed [CW-1:0]  pa_s [3], pb_s [3], pa_1 [3], pb_1 [3];
  logic signed [DLW-1:0] d1_s [3], d2_s [3];
  logic signed [APW-1:0] pda [3], pdb [3];
  logic signed [APW-1:0] sha [3], shb [3];
  logic signed [CW:0]    na_2 [3], nb_2 [3];
  logic signed [CW-1:0]  na_3 [3], nb_3 [3], na_o [3], nb_o [3];
  logic signed [SQW-1:0] sq_3 [3];
  logic signed [GW-1:0]  gsum;
  logic [GXW-1:0]        gsum_x;
  logic [GAP_WIDTH-1:0]  gap;
  logic                  va1, va2, va3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sha[i] = (pda[i] + APW'(ONE >> 1)) >>> RB;
      shb[i] = (pdb[i] + APW'(ONE >> 1)) >>> RB;
    end
    gsum   = GW'(sq_3[0]) + GW'(sq_3[1]) + GW'(sq_3[2]);
    gsum_x = GXW'(gsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsel          <= 1'b0;
      va1           <= 1'b0;
      va2           <= 1'b0;
      va3           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vsel          <= vl[DL];
      va1           <= vsel;
      va2           <= va1;
      va3           <= va2;
      m_axis_tvalid <= va3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sel <= s_mux;
      t_sel <= t_mux;
      for (int i = 0; i < 3; i++) begin
        pa_s[i] <= sd[DL].pa[i];
        pb_s[i] <= sd[DL].pb[i];
        d1_s[i] <= sd[DL].d1[i];
        d2_s[i] <= sd[DL].d2[i];
        // offsets along each segment
        pda[i]  <= d1_s[i] * $signed({1'b0, s_sel});
        pdb[i]  <= d2_s[i] * $signed({1'b0, t_sel});
        pa_1[i] <= pa_s[i];
        pb_1[i] <= pb_s[i];
        // near points, rounded half up
        na_2[i] <= (CW+1)'(pa_1[i]) + (CW+1)'(sha[i]);
        nb_2[i] <= (CW+1)'(pb_1[i]) + (CW+1)'(shb[i]);
        sq_3[i] <= ((CW+2)'(nb_2[i]) - (CW+2)'(na_2[i])) *
                   ((CW+2)'(nb_2[i]) - (CW+2)'(na_2[i]));
        na_3[i] <= na_2[i][CW-1:0];
        nb_3[i] <= nb_2[i][CW-1:0];
        na_o[i] <= na_3[i];
        nb_o[i] <= nb_3[i];
      end
      gap <= (|gsum_x[GXW-1:GAP_WIDTH]) ? '1 : gsum_x[GAP_WIDTH-1:0];
    end
  end

  assign m_axis_tdata = OW'({gap, nb_o[2], nb_o[1], nb_o[0], na_o[2], na_o[1], na_o[0]});

`ifndef ASSERT_OFF
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    vsel |-> (s_sel <= ONE) && (t_sel <= ONE))
    else $error("segment parameter above one");

  a_gap_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (gap == '0) |->
      (na_o[0] == nb_o[0]) && (na_o[1] == nb_o[1]) && (na_o[2] == nb_o[2]))
    else $error("zero gap with distinct near points");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result presented right after reset");
`endif
endmodule

// ----- rtl/cpseg_mul.sv -----
// Pipelined signed multiplier: one slice of operand b per stage.
`timescale 1ns / 1ps
module cpseg_mul import cpseg_pkg::*; #(
  parameter int WA = 68,
  parameter int WB = 68
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WA-1:0]      a,
  input  logic signed [WB-1:0]      b,
  output logic signed [WA+WB-1:0]   p
);
  localparam int NC = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BX = NC * MUL_CHUNK;
  localparam int PW = WA + WB;

  logic [BX-1:0]          bx;
  logic signed [WA-1:0]   a_q [NC];
  logic [BX-1:0]          b_q [NC];
  logic signed [PW-1:0]   acc [NC];

  assign bx = BX'(b);

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic signed [WA-1:0]          src_a;
    logic [BX-1:0]                 src_b;
    logic signed [MUL_CHUNK:0]     ck;
    logic signed [WA+MUL_CHUNK:0]  pr;
    logic signed [PW-1:0]          pp;

    if (k == 0) begin : g_first
      assign src_a = a;
      assign src_b = bx;
    end else begin : g_next
      assign src_a = a_q[k-1];
      assign src_b = b_q[k-1];
    end

    // only the top slice carries the sign
    if (k == NC - 1) begin : g_top
      assign ck = $signed({src_b[k*MUL_CHUNK+MUL_CHUNK-1], src_b[k*MUL_CHUNK +: MUL_CHUNK]});
    end else begin : g_low
      assign ck = $signed({1'b0, src_b[k*MUL_CHUNK +: MUL_CHUNK]});
    end

    assign pr = src_a * ck;
    assign pp = PW'(pr) <<< (k * MUL_CHUNK);

    if (k == 0) begin : g_acc_first
      always_ff @(posedge clk) begin
        if (en) begin
          a_q[k] <= src_a;
          b_q[k] <= src_b;
          acc[k] <= pp;
        end
      end
    end else begin : g_acc_next
      always_ff @(posedge clk) begin
        if (en) begin
          a_q[k] <= src_a;
          b_q[k] <= src_b;
          acc[k] <= acc[k-1] + pp;
        end
      end
    end
  end

  assign p = acc[NC-1];
endmodule

// ----- rtl/cpseg_ratio.sv -----
// Pipelined clamped ratio n/d in [0,1], one quotient bit per stage.
`timescale 1ns / 1ps
module cpseg_ratio import cpseg_pkg::*; #(
  parameter int W = 137
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [W-1:0]    n,
  input  logic signed [W-1:0]    d,
  output logic [RATIO_BITS:0]    q
);
  logic                   zf  [RATIO_BITS+1];
  logic                   of  [RATIO_BITS+1];
  logic [W-2:0]           rem [RATIO_BITS];
  logic [W-2:0]           dv  [RATIO_BITS];
  logic [RATIO_BITS-1:0]  qv  [RATIO_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0]  <= (d <= 0) || (n <= 0);
      of[0]  <= (d > 0) && (n > 0) && (n >= d);
      rem[0] <= n[W-2:0];
      dv[0]  <= d[W-2:0];
      qv[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= RATIO_BITS; k++) begin : g_bit
    logic [W-1:0] r2;
    logic [W-1:0] df;
    logic         ge;
    assign r2 = {rem[k-1], 1'b0};
    assign df = r2 - {1'b0, dv[k-1]};
    assign ge = r2 >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        zf[k] <= zf[k-1];
        of[k] <= of[k-1];
        qv[k] <= {qv[k-1][RATIO_BITS-2:0], ge};
      end
    end
    if (k < RATIO_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? df[W-2:0] : r2[W-2:0];
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  always_comb begin
    if (zf[RATIO_BITS]) begin
      q = '0;
    end else if (of[RATIO_BITS]) begin
      q = (RATIO_BITS+1)'(1) << RATIO_BITS;
    end else begin
      q = {1'b0, qv[RATIO_BITS]};
    end
  end
endmodule

// ----- dv/closest_points_between_segments_core_tb.sv -----
// Self-checking testbench for the segment closest-point pipeline.
`timescale 1ns / 1ps
module closest_points_between_segments_core_tb;
  import cpseg_pkg::*;

  localparam int CW       = 32;
  localparam int IN_BITS  = 12 * CW;
  localparam int OUT_BITS = 6 * CW + GAP_WIDTH;
  localparam int DRAIN    = 120;   // pipeline is 84 deep
  localparam int STALL_MAX = 5000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic [IN_BITS-1:0]  pair;
    bit                  known;
    logic [OUT_BITS-1:0] res;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [LIMIT_WIDTH-1:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;

  logic [LIMIT_WIDTH-1:0] seg_limit;
  logic [OUT_BITS-1:0] nearest_q[$];
  int  errors;
  int  idle_cycles;

  closest_points_between_segments_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] clamp_ratio(wide_t n, wide_t d);
    wide_t q;
    if (d <= 0 || n <= 0) return 64'd0;
    if (n >= d) return 64'd1 << RATIO_BITS;
    q = (n <<< RATIO_BITS) / d;
    return q[63:0];
  endfunction

  function automatic wide_t dot(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic wide_t lerp(wide_t p, wide_t d, logic [63:0] frac);
    wide_t fw, prod;
    fw = 0;
    fw[63:0] = frac;
    prod = d * fw + (wide_t'(1) <<< (RATIO_BITS - 1));
    return p + (prod >>> RATIO_BITS);
  endfunction

  function automatic logic [OUT_BITS-1:0] nearest_points(logic [IN_BITS-1:0] pair);
    wide_t pa[3], pb[3], d1[3], d2[3], r[3];
    wide_t a, b, c, e, f, lim, den, num, lenb, sw, na, nb, diff, gap;
    logic [63:0] s, t;
    logic [OUT_BITS-1:0] res;
    coord_t v;
    s = 0;
    t = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      v = pair[CW*i +: CW];       pa[i] = wide_t'(v);
      v = pair[CW*(3+i) +: CW];   d1[i] = wide_t'(v) - pa[i];
      v = pair[CW*(6+i) +: CW];   pb[i] = wide_t'(v);
      v = pair[CW*(9+i) +: CW];   d2[i] = wide_t'(v) - pb[i];
      r[i] = pa[i] - pb[i];
    end
    a = dot(d1, d1);
    b = dot(d1, d2);
    c = dot(d1, r);
    e = dot(d2, d2);
    f = dot(d2, r);
    lim = 0;
    lim[LIMIT_WIDTH-1:0] = seg_limit;
    if (a <= lim && e <= lim) begin
      s = 0;
    end else if (a <= lim) begin
      t = clamp_ratio(f, e);
    end else if (e <= lim) begin
      s = clamp_ratio(-c, a);
    end else begin
      den = a * e - b * b;
      s = (den == 0) ? 64'd0 : clamp_ratio(b * f - c * e, den);
      sw = 0;
      sw[63:0] = s;
      num = b * sw + (f <<< RATIO_BITS);
      lenb = e <<< RATIO_BITS;
      if (num < 0) begin
        t = 0;
        s = clamp_ratio(-c, a);
      end else if (num > lenb) begin
        t = 64'd1 << RATIO_BITS;
        s = clamp_ratio(b - c, a);
      end else begin
        t = clamp_ratio(num, lenb);
      end
    end
    gap = 0;
    for (int i = 0; i < 3; i++) begin
      na = lerp(pa[i], d1[i], s);
      nb = lerp(pb[i], d2[i], t);
      diff = nb - na;
      gap = gap + diff * diff;
      res[CW*i +: CW] = na[CW-1:0];
      res[CW*(3+i) +: CW] = nb[CW-1:0];
    end
    res[6*CW +: GAP_WIDTH] = (gap[255:64] != 0) ? {GAP_WIDTH{1'b1}} : gap[63:0];
    return res;
  endfunction

  function automatic logic [IN_BITS-1:0] seg_pair(
      coord_t sax, coord_t say, coord_t saz, coord_t eax, coord_t eay, coord_t eaz,
      coord_t sbx, coord_t sby, coord_t sbz, coord_t ebx, coord_t eby, coord_t ebz);
    return {ebz, eby, ebx, sbz, sby, sbx, eaz, eay, eax, saz, say, sax};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
  endfunction

  // random segment pair, biased toward the interesting geometric cases
  function automatic logic [IN_BITS-1:0] random_pair();
    coord_t c[12];
    int kind, k;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 12; i++)
      c[i] = (kind < 20) ? coord_t'($urandom) : small_coord();
    if (kind >= 45 && kind < 57) begin          // A shrinks to within one LSB per axis
      for (int i = 0; i < 3; i++) c[3+i] = c[i] + coord_t'($urandom_range(0, 1));
    end else if (kind >= 57 && kind < 69) begin // B shrinks to within one LSB per axis
      for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + coord_t'($urandom_range(0, 1));
    end else if (kind >= 69 && kind < 75) begin // both points
      for (int i = 0; i < 3; i++) begin
        c[3+i] = c[i];
        c[9+i] = c[6+i];
      end
    end else if (kind >= 75 && kind < 88) begin // parallel lines
      k = $urandom_range(0, 3) - 1;
      if (k == 0) k = 2;
      for (int i = 0; i < 3; i++)
        c[9+i] = c[6+i] + coord_t'(k * ((c[3+i] - c[i]) >>> 2));
    end
    return seg_pair(c[0], c[1], c[2], c[3], c[4], c[5],
                    c[6], c[7], c[8], c[9], c[10], c[11]);
  endfunction

  task automatic send_pair(logic [IN_BITS-1:0] pair);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    do @(posedge clk); while (!s_axis_tready);
    nearest_q = {nearest_q, nearest_points(pair)};
  endtask

  task automatic settle_and_write(logic [LIMIT_WIDTH-1:0] value);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (nearest_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    seg_limit = value;
  endtask

  // result side: bursts of ready, mostly short stalls, a few long ones
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (pick_gap() > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_res = nearest_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (m_axis_tdata[CW*i +: CW] !== exp_res[CW*i +: CW]) begin
            $display("%0t: near %s_%s expected %h actual %h", $time,
                     (i < 3) ? "a" : "b", (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                     exp_res[CW*i +: CW], m_axis_tdata[CW*i +: CW]);
            errors++;
          end
        if (m_axis_tdata[6*CW +: GAP_WIDTH] !== exp_res[6*CW +: GAP_WIDTH]) begin
          $display("%0t: gap_squared expected %h actual %h", $time,
                   exp_res[6*CW +: GAP_WIDTH], m_axis_tdata[6*CW +: GAP_WIDTH]);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    logic [LIMIT_WIDTH-1:0] limits[4];
    coord_t one, mn, mx;
    one = 32'sh0001_0000;
    mn = 32'sh8000_0000;
    mx = 32'sh7FFF_FFFF;
    errors = 0;
    idle_cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    seg_limit = LIMIT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero-length segments at the origin
    rw = '{seg_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0};
    rows = {rows, rw};
    // two points at opposite corners: distance saturates
    rw = '{seg_pair(mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx), 1'b1,
           {{GAP_WIDTH{1'b1}}, mx, mx, mx, mn, mn, mn}};
    rows = {rows, rw};
    // only A a point
    rw = '{seg_pair(0, one, 0, 0, one, 0, -one, 0, 0, one, 0, 0), 1'b0, '0};
    rows = {rows, rw};
    // only B a point
    rw = '{seg_pair(-one, 0, 0, one, 0, 0, 0, one, 3, 0, one, 3), 1'b0, '0};
    rows = {rows, rw};
    // skew segments crossing one unit apart, general case
    rw = '{seg_pair(-one, 0, 0, one, 0, 0, 0, -one, one, 0, one, one), 1'b0, '0};
    rows = {rows, rw};
    // parallel lines
    rw = '{seg_pair(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 0), 1'b0, '0};
    rows = {rows, rw};
    // t falls below zero, then above one
    rw = '{seg_pair(0, 0, 0, one, 0, 0, 2*one, one, 0, 3*one, 5*one, 0), 1'b0, '0};
    rows = {rows, rw};
    rw = '{seg_pair(0, 0, 0, one, 0, 0, 3*one, -5*one, 0, 2*one, -one, 0), 1'b0, '0};
    rows = {rows, rw};
    // skew lines with both parameters clamped
    rw = '{seg_pair(0, 0, 0, one, 0, 0, 5*one, one, -one, 6*one, 2*one, one), 1'b0, '0};
    rows = {rows, rw};
    // full-range endpoints
    rw = '{seg_pair(mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn), 1'b0, '0};
    rows = {rows, rw};
    rw = '{seg_pair(mx, mn, 0, mn, mx, 0, mn, mn, mx, mx, mx, mn), 1'b0, '0};
    rows = {rows, rw};
    // segment of length one LSB sits on the limit, then one just above it
    rw = '{seg_pair(5, 5, 5, 6, 5, 5, -one, 0, 0, one, 0, 0), 1'b0, '0};
    rows = {rows, rw};
    rw = '{seg_pair(5, 5, 5, 6, 6, 5, -one, 0, 0, one, 0, 0), 1'b0, '0};
    rows = {rows, rw};

    foreach (rows[i]) begin
      send_pair(rows[i].pair);
      if (rows[i].known && nearest_q[$] !== rows[i].res) begin
        $display("%0t: row %0d predicted %h expected %h", $time, i,
                 nearest_q[$], rows[i].res);
        errors++;
      end
    end
    for (int n = 0; n < 300; n++) send_pair(random_pair());

    limits[0] = '0;
    limits[1] = '1;
    limits[2] = $urandom;
    limits[3] = 32'h0010_0000;
    foreach (limits[p]) begin
      settle_and_write(limits[p]);
      for (int n = 0; n < 285; n++) send_pair(random_pair());
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (nearest_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
